/* sv/efr_pkg.sv */
// Shared constants and types for the escaped frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

  localparam logic [7:0] START_BYTE  = 8'h7E;
  localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
  localparam logic [7:0] ESCAPE_XOR  = 8'h20;

  // Receiver phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  // One result beat
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       frame_done;
    logic       frame_ok;
  } efr_result_t;

endpackage

`default_nettype wire

/* sv/efr_byte_if.sv */
// Input channel: one raw link byte per beat.
`timescale 1ns / 1ps
`default_nettype none

interface efr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

`default_nettype wire

/* sv/efr_result_if.sv */
// Result channel: one deframed result per beat.
`timescale 1ns / 1ps
`default_nettype none

interface efr_result_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic       frame_done;
  logic       frame_ok;

  modport source (output valid, output data_valid, output data_byte, output data_index,
                  output frame_done, output frame_ok, input ready);
  modport sink (input valid, input data_valid, input data_byte, input data_index,
                input frame_done, input frame_ok, output ready);
endinterface

`default_nettype wire

/* sv/efr_in_reg.sv */
// Input register stage: holds one received byte until the core takes it.
`timescale 1ns / 1ps
`default_nettype none

module efr_in_reg (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] in_byte,
  input  wire        take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  // Accept a new beat when empty or when the held byte moves on this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

`default_nettype wire

/* sv/efr_core.sv */
// Deframing core: phase, escape and checksum state with the per-byte update.
`timescale 1ns / 1ps
`default_nettype none

module efr_core
  import efr_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          step,
  input  wire    [7:0] byte_i,
  output efr_result_t  res
);

  phase_t     phase_r, phase_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] check_r, check_nxt;
  logic [7:0] widx_r, widx_nxt;

  logic [7:0] ub;
  logic       is_mark;

  // Unescape the incoming byte
  assign ub      = esc_r ? (byte_i ^ ESCAPE_XOR) : byte_i;
  assign is_mark = !esc_r && (byte_i == ESCAPE_BYTE);

  // Compute next state and the result for this byte
  always_comb begin
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    remain_nxt = remain_r;
    check_nxt  = check_r;
    widx_nxt   = widx_r;
    res        = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (byte_i == START_BYTE) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        esc_nxt = is_mark;
        if (!is_mark) begin
          remain_nxt     = ub;
          check_nxt      = ub;
          res.data_valid = 1'b1;
          res.data_byte  = ub;
          widx_nxt       = 8'd1;
          phase_nxt      = PH_BODY;
        end
      end
      PH_BODY: begin
        esc_nxt = is_mark;
        if (!is_mark) begin
          if (remain_r != 8'd0) begin
            remain_nxt     = remain_r - 8'd1;
            check_nxt      = check_r ^ ub;
            res.data_valid = 1'b1;
            res.data_byte  = ub;
            res.data_index = widx_r;
            widx_nxt       = widx_r + 8'd1;
          end else begin
            res.frame_done = 1'b1;
            res.frame_ok   = (check_r == ub);
            phase_nxt      = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Advance state only when a byte is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      esc_r    <= 1'b0;
      remain_r <= 8'd0;
      check_r  <= 8'd0;
      widx_r   <= 8'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      esc_r    <= esc_nxt;
      remain_r <= remain_nxt;
      check_r  <= check_nxt;
      widx_r   <= widx_nxt;
    end
  end

  // An escape never survives into idle
  a_idle_no_esc: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> !esc_r)
    else $error("escape pending while idle");

  // A closing checksum returns the receiver to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.frame_done) |=> (phase_r == PH_IDLE))
    else $error("frame close did not return to idle");

  // Each stored payload byte advances the index and consumes one count
  a_payload_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.data_valid && (phase_r == PH_BODY)) |=>
      (widx_r == $past(widx_r) + 8'd1) && (remain_r == $past(remain_r) - 8'd1))
    else $error("payload step did not advance index and count");

  // Hold state while no byte is processed
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(phase_r) && $stable(esc_r) && $stable(check_r)))
    else $error("state changed without a byte");

endmodule

`default_nettype wire

/* sv/efr_out_reg.sv */
// Result register stage: holds one result beat until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module efr_out_reg
  import efr_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          load_valid,
  input  efr_result_t  load_res,
  output logic         can_load,
  output logic         out_valid,
  input  wire          out_ready,
  output efr_result_t  out_res
);

  logic        valid_r, valid_nxt;
  efr_result_t res_r;

  // Free when empty or when the waiting beat is taken this cycle
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = can_load ? load_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the result when a byte moves in
  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

/* sv/escaped_frame_receiver_top.sv */
// Top level of the escaped frame receiver.
`timescale 1ns / 1ps
`default_nettype none

// Byte-stuffed frame receiver: hunts for the start byte 0x7E, drops the escape
// byte 0x7D and XORs the following byte with 0x20, then reports the length byte
// at index 0, payload bytes at index 1..L, and on the trailing XOR checksum a
// frame_done beat with frame_ok showing whether it matched. Every input beat
// yields exactly one result beat. Throughput is one byte per clock while the
// result channel is ready; a byte passes the input register, then the result
// register, with the whole per-byte state update done combinationally between.
module escaped_frame_receiver_top
  import efr_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  efr_byte_if.sink    in_bus,
  efr_result_if.source out_bus
);

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        can_load;
  logic        step;
  efr_result_t core_res;
  efr_result_t out_res;

  assign step = held_valid && can_load;

  efr_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_byte    (in_bus.byte_in),
    .take       (can_load),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  efr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .byte_i (held_byte),
    .res    (core_res)
  );

  efr_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (held_valid),
    .load_res   (core_res),
    .can_load   (can_load),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_res    (out_res)
  );

  assign out_bus.data_valid = out_res.data_valid;
  assign out_bus.data_byte  = out_res.data_byte;
  assign out_bus.data_index = out_res.data_index;
  assign out_bus.frame_done = out_res.frame_done;
  assign out_bus.frame_ok   = out_res.frame_ok;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the escaped frame receiver top level.
`timescale 1ns / 1ps

module tb
  import efr_pkg::*;
();

  logic clk;
  logic rst_n;

  efr_byte_if   in_bus ();
  efr_result_if out_bus ();

  escaped_frame_receiver_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Raw link bytes waiting to be sent, deframed beats waiting to come back
  logic [7:0]  link_bytes[$];
  efr_result_t deframed_beats[$];

  int failures = 0;
  int results_seen = 0;
  int idle_noise = 0;

  // Handshake bookkeeping
  logic byte_taken = 1'b0;
  logic result_taken = 1'b0;
  logic hold_off = 1'b0;
  int   send_wait = 0;
  int   send_gap_max = 0;
  int   sent_count = 0;
  int   recv_wait = 0;
  int   recv_gap_max = 0;
  int   recv_count = 0;

  // Deframer state, kept in step with the block
  phase_t     rx_phase = PH_IDLE;
  logic       esc_pending = 1'b0;
  logic [7:0] left_count = '0;
  logic [7:0] check_acc = '0;
  logic [7:0] next_index = '0;

  efr_result_t want_beat;

  // Advance the deframer by one raw byte and return the beat it produces
  function automatic efr_result_t deframe_byte(input logic [7:0] raw);
    efr_result_t r;
    logic [7:0]  b;
    logic        have;
    r = '0;
    b = raw;
    have = 1'b1;
    // Unescape only inside a frame
    if (rx_phase == PH_LEN || rx_phase == PH_BODY) begin
      if (esc_pending) begin
        esc_pending = 1'b0;
        b = raw ^ ESCAPE_XOR;
      end else if (raw == ESCAPE_BYTE) begin
        esc_pending = 1'b1;
        have = 1'b0;
      end
    end
    case (rx_phase)
      PH_IDLE: begin
        if (raw == START_BYTE) rx_phase = PH_LEN;
      end
      PH_LEN: begin
        if (have) begin
          left_count = b;
          check_acc = b;
          r.data_valid = 1'b1;
          r.data_byte = b;
          r.data_index = '0;
          next_index = 8'd1;
          rx_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (have) begin
          if (left_count != 0) begin
            left_count = left_count - 8'd1;
            check_acc = check_acc ^ b;
            r.data_valid = 1'b1;
            r.data_byte = b;
            r.data_index = next_index;
            next_index = next_index + 8'd1;
          end else begin
            r.frame_done = 1'b1;
            r.frame_ok = (check_acc == b);
            rx_phase = PH_IDLE;
          end
        end
      end
      default: rx_phase = PH_IDLE;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 14;
    endcase
  endfunction

  // Payload byte, biased toward the framing codes and the extremes
  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 5) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return START_BYTE;
      1: return ESCAPE_BYTE;
      2: return 8'h00;
      3: return 8'hFF;
      4: return START_BYTE ^ ESCAPE_XOR;
      default: return ESCAPE_BYTE ^ ESCAPE_XOR;
    endcase
  endfunction

  // Queue one frame byte, escaping the codes and now and then any byte
  task automatic push_stuffed(input logic [7:0] b);
    if (b == START_BYTE || b == ESCAPE_BYTE || $urandom_range(0, 15) == 0) begin
      link_bytes.push_back(ESCAPE_BYTE);
      link_bytes.push_back(b ^ ESCAPE_XOR);
    end else begin
      link_bytes.push_back(b);
    end
  endtask

  // Queue a whole frame; a cut length >= 0 truncates the raw stream there
  task automatic queue_frame(input int len, input bit bad_sum, input int cut_at);
    logic [7:0] sum;
    logic [7:0] b;
    int         base;
    base = link_bytes.size();
    link_bytes.push_back(START_BYTE);
    sum = 8'(len);
    push_stuffed(8'(len));
    for (int k = 0; k < len; k++) begin
      b = payload_byte();
      sum = sum ^ b;
      push_stuffed(b);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    push_stuffed(sum);
    if (cut_at >= 0) begin
      while (link_bytes.size() > base + cut_at) void'(link_bytes.pop_back());
    end
  endtask

  task automatic queue_noise();
    logic [7:0] b;
    int         n;
    n = $urandom_range(1, 5);
    for (int k = 0; k < n; k++) begin
      b = payload_byte();
      if (b == START_BYTE) b = 8'hFF;
      link_bytes.push_back(b);
    end
    idle_noise += n;
  endtask

  task automatic build_stimulus();
    int frames;
    int pick;
    int len;
    // Idle noise, including an escape byte that must be ignored
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(ESCAPE_BYTE);
    link_bytes.push_back(8'h41);
    // Zero length: checksum right after the length
    link_bytes.push_back(START_BYTE);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'h00);
    // Escaped length 2, a bare start byte as data, an escaped escape byte,
    // and an escaped checksum of 0x01
    link_bytes.push_back(START_BYTE);
    link_bytes.push_back(ESCAPE_BYTE);
    link_bytes.push_back(8'h22);
    link_bytes.push_back(START_BYTE);
    link_bytes.push_back(ESCAPE_BYTE);
    link_bytes.push_back(8'h5D);
    link_bytes.push_back(ESCAPE_BYTE);
    link_bytes.push_back(8'h21);
    // Mismatched checksum
    link_bytes.push_back(START_BYTE);
    link_bytes.push_back(8'h01);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(8'h00);
    // Escape of an ordinary byte: 0x20 becomes 0x00
    link_bytes.push_back(START_BYTE);
    link_bytes.push_back(8'h01);
    link_bytes.push_back(ESCAPE_BYTE);
    link_bytes.push_back(8'h20);
    link_bytes.push_back(8'h01);

    // Random part: mostly well-formed frames, some noise and broken frames
    frames = 0;
    while (link_bytes.size() - idle_noise < 700) begin
      pick = $urandom_range(0, 99);
      if (frames == 10) begin
        // Longest frame, runs the index up to its top value 255
        queue_frame(255, $urandom_range(0, 1), -1);
      end else if (pick < 8) begin
        queue_noise();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(0, 8);
        else if (pick < 95) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 120);
        if ($urandom_range(0, 99) < 7)
          queue_frame(len, 1'b0, $urandom_range(1, len + 3));
        else
          queue_frame(len, $urandom_range(0, 99) < 15, -1);
      end
      frames++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset, stimulus, and the end of the run
  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.byte_in = '0;
    out_bus.ready = 1'b0;
    build_stimulus();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (link_bytes.size() != 0 || in_bus.valid) @(posedge clk);
    while (deframed_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("escaped_frame_receiver_top regression: pass");
    end else begin
      $display("escaped_frame_receiver_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("escaped_frame_receiver_top regression: fail");
    $finish;
  end

  // Long receiver hold-off so the block fills and stalls its input
  initial begin
    while (results_seen < 200) @(posedge clk);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Drive link bytes with random gaps between beats
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_bus.valid || byte_taken) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_bus.valid <= 1'b0;
        end else if (link_bytes.size() != 0) begin
          in_bus.byte_in <= link_bytes.pop_front();
          in_bus.valid <= 1'b1;
          send_wait <= $urandom_range(0, send_gap_max);
          sent_count <= sent_count + 1;
          if (sent_count % 40 == 39) send_gap_max <= pick_gap_max();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result channel a random number of cycles after each beat
  always @(negedge clk) begin
    if (rst_n) begin
      if (result_taken) begin
        recv_wait = $urandom_range(0, recv_gap_max);
        recv_count++;
        if (recv_count % 50 == 0) recv_gap_max = pick_gap_max();
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_bus.ready <= (recv_wait == 0) && !hold_off;
    end
  end

  // Predict on every accepted byte, check every accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_phase = PH_IDLE;
      esc_pending = 1'b0;
      left_count = '0;
      check_acc = '0;
      next_index = '0;
      byte_taken <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      byte_taken <= in_bus.valid && in_bus.ready;
      result_taken <= out_bus.valid && out_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        deframed_beats.push_back(deframe_byte(in_bus.byte_in));
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (deframed_beats.size() == 0) begin
          $error("result beat with no byte outstanding");
          failures++;
        end else begin
          want_beat = deframed_beats.pop_front();
          check_field("data_valid", 8'(want_beat.data_valid), 8'(out_bus.data_valid));
          check_field("data_byte", want_beat.data_byte, out_bus.data_byte);
          check_field("data_index", want_beat.data_index, out_bus.data_index);
          check_field("frame_done", 8'(want_beat.frame_done), 8'(out_bus.frame_done));
          check_field("frame_ok", 8'(want_beat.frame_ok), 8'(out_bus.frame_ok));
        end
      end
    end
  end

endmodule
